FILE: hdl/assert_macros.svh
// assertion macros used by the checker file nqpt_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while the active-low reset is low
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication form of the above
`define ASSERT_IMPL(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

`endif

FILE: hdl/nqpt_pkg.sv
// types and constants of the nvme queue pair tracker
// no dependencies
package nqpt_pkg;

    localparam int unsigned MAX_DEPTH_DEF = 65536;

    localparam logic [16:0] QUEUE_DEPTH_RST = 17'd64;
    localparam logic [15:0] QUEUE_ID_RST    = 16'd0;
    localparam logic [31:0] ADMIN_TO_RST    = 32'd60000;
    localparam logic [31:0] IO_TO_RST       = 32'd30000;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 48;
    localparam int unsigned S_TUSER_W  = 2;
    localparam int unsigned M_TDATA_W  = 120;

    typedef enum logic [1:0] {
        REQ_SUBMIT = 2'd0,
        REQ_CPL    = 2'd1,
        REQ_ARM    = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        WAIT_NONE    = 2'd0,
        WAIT_OK      = 2'd1,
        WAIT_FAIL    = 2'd2,
        WAIT_TIMEOUT = 2'd3
    } wres_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUE_DEPTH = 2'd0,
        CFG_QUEUE_ID    = 2'd1,
        CFG_ADMIN_TO    = 2'd2,
        CFG_IO_TO       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] wait_cid;
        logic [15:0] entry_cid;
        logic [15:0] entry_status;
    } in_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic        is_empty;
        logic        is_full;
        logic [15:0] outstanding;
        wres_t       wait_result;
        logic [15:0] cpl_status_out;
        logic [15:0] cpl_cid_out;
        logic        cpl_valid;
        logic [15:0] cq_head_new;
        logic [15:0] sq_tail_new;
        logic [15:0] sq_slot;
        logic [15:0] cid_out;
        logic        accepted;
    } result_t;

endpackage

FILE: hdl/nvme_queue_pair_tracker.sv
// Host-side tracker for one NVMe submission/completion queue pair: submit, completion,
// arm-wait and tick requests, one result beat per request beat. Depends on nqpt_pkg.
//
// Takes one request beat per clock unless stalled and returns one result beat per request.
// The request lands in an input register, the pointer, phase and wait update is one level of
// compare-and-increment logic, and the result sits in an output register. A stalled result
// still lets one more request into the input register, then s_tready drops until the result
// is taken. The user must write configuration through cfg_we / cfg_index / cfg_wdata only
// while no request is in flight; the block does not enforce it. Reset has no clearing pass.
module nvme_queue_pair_tracker #(
    parameter int unsigned MAX_DEPTH = nqpt_pkg::MAX_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [nqpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nqpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_status, entry_cid, wait_cid
    input  logic [nqpt_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic [nqpt_pkg::S_TUSER_W-1:0]   s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // accepted, cid_out, sq_slot, new sq tail, new cq head, cpl_valid, cpl_cid_out,
    // cpl_status_out, wait_result, outstanding, is_full, is_empty, zero pad
    output logic [nqpt_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned PTR_W   = $clog2(MAX_DEPTH);
    localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

    // configuration registers
    logic [16:0] queue_depth_reg;
    logic [15:0] queue_id_reg;
    logic [31:0] admin_to_reg;
    logic [31:0] io_to_reg;

    // queue and wait state
    logic [PTR_W-1:0] sub_tail_reg, sub_tail_next;
    logic [PTR_W-1:0] cpl_head_reg, cpl_head_next;
    logic             phase_reg, phase_next;
    logic [15:0]      next_ident_reg, next_ident_next;
    logic             wait_armed_reg, wait_armed_next;
    logic [15:0]      awaited_ident_reg, awaited_ident_next;
    logic [31:0]      wait_elapsed_reg, wait_elapsed_next;

    // input and output stages
    logic             in_valid_reg;
    nqpt_pkg::req_t   in_type_reg;
    nqpt_pkg::in_t    in_data_reg;
    logic             out_valid_reg;
    nqpt_pkg::result_t out_reg, result_next;

    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    function automatic logic [DEPTH_W-1:0] occupancy(
        input logic [DEPTH_W-1:0] t,
        input logic [DEPTH_W-1:0] h,
        input logic [DEPTH_W-1:0] d
    );
        return (t >= h) ? (t - h) : (d - h + t);
    endfunction

    logic [DEPTH_W-1:0] depth_use;
    logic [DEPTH_W-1:0] tail_use, head_use;
    logic [DEPTH_W-1:0] tail_inc, head_inc;
    logic [DEPTH_W-1:0] tail_after, head_after;
    logic [DEPTH_W-1:0] occ_before, occ_after;
    logic [31:0]        limit;
    logic [31:0]        elapsed_inc;

    always_comb begin
        if (queue_depth_reg < 17'd2) begin
            depth_use = DEPTH_W'(2);
        end else if (queue_depth_reg > 17'(MAX_DEPTH)) begin
            depth_use = DEPTH_W'(MAX_DEPTH);
        end else begin
            depth_use = DEPTH_W'(queue_depth_reg);
        end

        // a pointer left beyond a shrunk depth reads as zero
        tail_use = (DEPTH_W'(sub_tail_reg) >= depth_use) ? '0 : DEPTH_W'(sub_tail_reg);
        head_use = (DEPTH_W'(cpl_head_reg) >= depth_use) ? '0 : DEPTH_W'(cpl_head_reg);
        tail_inc = tail_use + DEPTH_W'(1);
        head_inc = head_use + DEPTH_W'(1);
        occ_before = occupancy(tail_use, head_use, depth_use);

        limit       = (queue_id_reg == 16'd0) ? admin_to_reg : io_to_reg;
        elapsed_inc = (wait_elapsed_reg == '1) ? wait_elapsed_reg : wait_elapsed_reg + 32'd1;

        // pointers keep their raw value unless the request moves them
        sub_tail_next      = sub_tail_reg;
        cpl_head_next      = cpl_head_reg;
        phase_next         = phase_reg;
        next_ident_next    = next_ident_reg;
        wait_armed_next    = wait_armed_reg;
        awaited_ident_next = awaited_ident_reg;
        wait_elapsed_next  = wait_elapsed_reg;
        result_next        = '0;
        result_next.wait_result = nqpt_pkg::WAIT_NONE;

        unique case (in_type_reg)
            nqpt_pkg::REQ_SUBMIT: begin
                if (occ_before < depth_use - DEPTH_W'(1)) begin
                    sub_tail_next           = (tail_inc >= depth_use) ? '0 : PTR_W'(tail_inc);
                    next_ident_next         = next_ident_reg + 16'd1;
                    result_next.accepted    = 1'b1;
                    result_next.cid_out     = next_ident_reg;
                    result_next.sq_slot     = 16'(tail_use);
                    result_next.sq_tail_new = 16'(sub_tail_next);
                end else begin
                    sub_tail_next = sub_tail_reg;
                end
            end
            nqpt_pkg::REQ_CPL: begin
                if (in_data_reg.entry_status[0] == phase_reg) begin
                    if (head_inc >= depth_use) begin
                        cpl_head_next = '0;
                        phase_next    = !phase_reg;
                    end else begin
                        cpl_head_next = PTR_W'(head_inc);
                    end
                    result_next.cq_head_new    = 16'(cpl_head_next);
                    result_next.cpl_valid      = 1'b1;
                    result_next.cpl_cid_out    = in_data_reg.entry_cid;
                    result_next.cpl_status_out = in_data_reg.entry_status;
                    if (wait_armed_reg && in_data_reg.entry_cid == awaited_ident_reg) begin
                        // status code and code type zero means success
                        result_next.wait_result = (in_data_reg.entry_status[11:1] == 11'd0)
                                                  ? nqpt_pkg::WAIT_OK : nqpt_pkg::WAIT_FAIL;
                        wait_armed_next = 1'b0;
                    end
                end else begin
                    cpl_head_next = cpl_head_reg;
                end
            end
            nqpt_pkg::REQ_ARM: begin
                wait_armed_next    = 1'b1;
                awaited_ident_next = in_data_reg.wait_cid;
                wait_elapsed_next  = '0;
            end
            nqpt_pkg::REQ_TICK: begin
                if (wait_armed_reg) begin
                    wait_elapsed_next = elapsed_inc;
                    if (elapsed_inc >= limit) begin
                        result_next.wait_result = nqpt_pkg::WAIT_TIMEOUT;
                        wait_armed_next         = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        tail_after = (DEPTH_W'(sub_tail_next) >= depth_use) ? '0 : DEPTH_W'(sub_tail_next);
        head_after = (DEPTH_W'(cpl_head_next) >= depth_use) ? '0 : DEPTH_W'(cpl_head_next);
        occ_after               = occupancy(tail_after, head_after, depth_use);
        result_next.outstanding = 16'(occ_after);
        result_next.is_full     = (occ_after >= depth_use - DEPTH_W'(1));
        result_next.is_empty    = (occ_after == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_depth_reg   <= nqpt_pkg::QUEUE_DEPTH_RST;
            queue_id_reg      <= nqpt_pkg::QUEUE_ID_RST;
            admin_to_reg      <= nqpt_pkg::ADMIN_TO_RST;
            io_to_reg         <= nqpt_pkg::IO_TO_RST;
            sub_tail_reg      <= '0;
            cpl_head_reg      <= '0;
            phase_reg         <= 1'b1;
            next_ident_reg    <= '0;
            wait_armed_reg    <= 1'b0;
            awaited_ident_reg <= '0;
            wait_elapsed_reg  <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (nqpt_pkg::cfg_idx_t'(cfg_index))
                    nqpt_pkg::CFG_QUEUE_DEPTH: queue_depth_reg <= cfg_wdata[16:0];
                    nqpt_pkg::CFG_QUEUE_ID:    queue_id_reg    <= cfg_wdata[15:0];
                    nqpt_pkg::CFG_ADMIN_TO:    admin_to_reg    <= cfg_wdata;
                    nqpt_pkg::CFG_IO_TO:       io_to_reg       <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end

            if (advance) begin
                sub_tail_reg      <= sub_tail_next;
                cpl_head_reg      <= cpl_head_next;
                phase_reg         <= phase_next;
                next_ident_reg    <= next_ident_next;
                wait_armed_reg    <= wait_armed_next;
                awaited_ident_reg <= awaited_ident_next;
                wait_elapsed_reg  <= wait_elapsed_next;
                out_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= nqpt_pkg::req_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

endmodule

FILE: hdl/nqpt_checker.sv
// port-level checks for nvme_queue_pair_tracker, attached by bind
// depends on nqpt_pkg and assert_macros.svh
`include "assert_macros.svh"

module nqpt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nqpt_pkg::M_TDATA_W-1:0] m_tdata
);

    nqpt_pkg::result_t res;
    logic stall;
    logic full_empty;
    logic sub_beat;
    logic cpl_quiet;
    logic no_sub;
    logic sub_clear;
    logic no_cpl;
    logic cpl_clear;

    assign res        = m_tdata;
    assign stall      = m_tvalid && !m_tready;
    assign full_empty = res.is_full && res.is_empty;
    assign sub_beat   = m_tvalid && res.accepted;
    assign cpl_quiet  = !res.cpl_valid && res.wait_result == nqpt_pkg::WAIT_NONE;
    assign no_sub     = m_tvalid && !res.accepted;
    assign sub_clear  = res.cid_out == 16'd0 && res.sq_slot == 16'd0
                        && res.sq_tail_new == 16'd0;
    assign no_cpl     = m_tvalid && !res.cpl_valid;
    assign cpl_clear  = res.cq_head_new == 16'd0 && res.cpl_cid_out == 16'd0
                        && res.cpl_status_out == 16'd0;

    // a stalled result beat stays put
    `ASSERT_CLK(a_out_hold, aclk, aresetn, stall |=> m_tvalid && $stable(res), "held beat changed")

    // depth is at least two, so a full queue is never empty
    `ASSERT_IMPL(a_full_empty, aclk, aresetn, m_tvalid, !full_empty, "full and empty")

    // a submit result carries no completion or wait outcome
    `ASSERT_IMPL(a_submit_excl, aclk, aresetn, sub_beat, cpl_quiet, "submit mixed with completion")

    // submit fields are zero unless a slot was taken
    `ASSERT_IMPL(a_submit_zero, aclk, aresetn, no_sub, sub_clear, "submit fields on refused beat")

    // completion fields are zero unless an entry was consumed
    `ASSERT_IMPL(a_cpl_zero, aclk, aresetn, no_cpl, cpl_clear, "completion fields on idle beat")

endmodule

bind nvme_queue_pair_tracker nqpt_checker u_nqpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
